FILE: rtl/rbsi_pkg.sv
// Package for the ray/box slab intersection core.
// Holds default widths, register indexes and the stage sideband type.
// No dependencies.
package rbsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;
  localparam int NUM_SLABS       = 6;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  // per-item flags that travel beside the dividers
  typedef struct packed {
    logic                 valid;
    logic [NUM_AXES-1:0]  dzero;  // direction component is zero
    logic [NUM_AXES-1:0]  zmiss;  // origin outside that slab
    logic [NUM_AXES-1:0]  sneg;   // direction component negative
    logic [NUM_SLABS-1:0] dneg;   // plane lies behind the origin
  } side_t;

endpackage

FILE: rtl/rbsi_div_pipe.sv
// Pipelined fixed-point divider for one slab: floor(dmag * 2^F / smag).
// One setup stage, then one quotient bit per stage. Uses rbsi_pkg nothing.
module rbsi_div_pipe #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_WIDTH-1:0] dmag,
  input  logic [COORD_WIDTH-1:0] smag,
  output logic [COORD_WIDTH-2:0] quot,
  output logic                   sat
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int CW = 2 * W + FRAC_BITS;

  logic [W-1:0] rem  [W];
  logic [W-1:0] dvs  [W];
  logic [W-2:0] nlow [W];
  logic [W-2:0] qacc [W];
  logic         sflg [W];

  logic [NW-1:0] nfull;
  logic [CW-1:0] nx;
  logic [CW-1:0] dx;

  assign nfull = {dmag, {FRAC_BITS{1'b0}}};
  assign nx    = CW'(nfull);
  assign dx    = CW'(smag) << (W - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      sflg[0] <= (nx >= dx);
      rem[0]  <= W'(nfull >> (W - 1));
      nlow[0] <= nfull[W-2:0];
      qacc[0] <= '0;
      dvs[0]  <= smag;
    end
  end

  for (genvar k = 1; k < W; k++) begin : g_step
    logic [W:0] trial;
    assign trial = {rem[k-1], nlow[k-1][W-2]} - {1'b0, dvs[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[W]) begin
          rem[k]  <= trial[W-1:0];
          qacc[k] <= {qacc[k-1][W-3:0], 1'b1};
        end else begin
          rem[k]  <= {rem[k-1][W-2:0], nlow[k-1][W-2]};
          qacc[k] <= {qacc[k-1][W-3:0], 1'b0};
        end
        nlow[k] <= {nlow[k-1][W-3:0], 1'b0};
        dvs[k]  <= dvs[k-1];
        sflg[k] <= sflg[k-1];
      end
    end
  end

  assign quot = qacc[W-1];
  assign sat  = sflg[W-1];

endmodule

FILE: rtl/rbsi_resolve.sv
// Sign, saturation and slab combine for the six quotients, then hit test.
// Two stages; the last one is the output register. Uses rbsi_pkg.
module rbsi_resolve #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [COORD_WIDTH-2:0] quot [rbsi_pkg::NUM_SLABS],
  input  logic [rbsi_pkg::NUM_SLABS-1:0] sat,
  input  rbsi_pkg::side_t        side,
  output logic                   out_valid,
  output logic                   hit,
  output logic [COORD_WIDTH-1:0] distance
);

  localparam int W = COORD_WIDTH;
  localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MISS_VAL =
      (FRAC_BITS >= W - 1) ? MIN_NEG : (W'(0) - (W'(1) << FRAC_BITS));

  logic signed [W-1:0] sdist [rbsi_pkg::NUM_SLABS];
  logic signed [W-1:0] e_next [rbsi_pkg::NUM_AXES];
  logic signed [W-1:0] x_next [rbsi_pkg::NUM_AXES];
  logic signed [W-1:0] ent [rbsi_pkg::NUM_AXES];
  logic signed [W-1:0] ext [rbsi_pkg::NUM_AXES];
  logic                c_valid;
  logic                c_zmiss;
  logic signed [W-1:0] t_in;
  logic signed [W-1:0] t_out;
  logic                miss;

  always_comb begin
    for (int s = 0; s < rbsi_pkg::NUM_SLABS; s++) begin
      if (side.dneg[s] ^ side.sneg[s/2]) begin
        sdist[s] = sat[s] ? MIN_NEG : (W'(0) - {1'b0, quot[s]});
      end else begin
        sdist[s] = sat[s] ? MAX_POS : {1'b0, quot[s]};
      end
    end
    for (int a = 0; a < rbsi_pkg::NUM_AXES; a++) begin
      if (side.dzero[a]) begin
        e_next[a] = MIN_NEG;
        x_next[a] = MAX_POS;
      end else if (side.sneg[a]) begin
        e_next[a] = sdist[2*a+1];
        x_next[a] = sdist[2*a];
      end else begin
        e_next[a] = sdist[2*a];
        x_next[a] = sdist[2*a+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= side.valid;
    end
    if (en) begin
      c_zmiss <= |(side.dzero & side.zmiss);
      ent     <= e_next;
      ext     <= x_next;
    end
  end

  always_comb begin
    t_in  = ent[0];
    t_out = ext[0];
    for (int a = 1; a < rbsi_pkg::NUM_AXES; a++) begin
      if (ent[a] > t_in) t_in = ent[a];
      if (ext[a] < t_out) t_out = ext[a];
    end
    miss = c_zmiss || t_out[W-1] || (t_in > t_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
    if (en) begin
      hit      <= !miss;
      distance <= miss ? MISS_VAL : t_in;
    end
  end

endmodule

FILE: rtl/ray_box_slab_intersect_core.sv
// Top level of the ray/box slab intersection core: box registers, slab setup,
// six divider pipelines and the combine stage. Uses rbsi_pkg, rbsi_div_pipe,
// rbsi_resolve.
//
//  channel | dir | fields
//  s_*     | in  | tdata: origin_x/y/z, direction_x/y/z
//  m_*     | out | tuser: hit; tdata: distance
//  cfg_*   | in  | box_min_x/y/z, box_max_x/y/z at index 0..5
//
// One ray per cycle while the output is not stalled; the stages are one setup stage,
// one divider setup stage, COORD_WIDTH-1 quotient-bit stages and two combine stages.
// Synchronous reset clears valid bits and the box to zero.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module ray_box_slab_intersect_core #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // distance
  output logic [((COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // hit
  output logic [0:0] m_tuser,
  input  logic                            cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int NA = rbsi_pkg::NUM_AXES;
  localparam int NS = rbsi_pkg::NUM_SLABS;
  localparam int OB = ((W + 7) / 8) * 8;

  logic signed [W-1:0] box_lo [NA];
  logic signed [W-1:0] box_hi [NA];

  logic en;
  logic in_acc;

  logic signed [W-1:0] org [NA];
  logic signed [W-1:0] dir [NA];
  logic signed [W:0]   diff [NS];
  logic signed [W:0]   dneg_w [NA];
  logic [W-1:0]        dmag_next [NS];
  logic [W-1:0]        smag_next [NA];
  rbsi_pkg::side_t     side_next;

  logic [W-1:0]        dmag [NS];
  logic [W-1:0]        smag [NA];
  rbsi_pkg::side_t     side_a;
  rbsi_pkg::side_t     side_d [W];

  logic [W-2:0]        quot [NS];
  logic [NS-1:0]       sat;
  logic [W-1:0]        distance;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign in_acc   = s_tvalid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        box_lo[a] <= '0;
        box_hi[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbsi_pkg::REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    side_next.valid = in_acc;
    for (int a = 0; a < NA; a++) begin
      org[a] = s_tdata[a*W +: W];
      dir[a] = s_tdata[(a+3)*W +: W];
      diff[2*a]   = (W+1)'(box_lo[a]) - (W+1)'(org[a]);
      diff[2*a+1] = (W+1)'(box_hi[a]) - (W+1)'(org[a]);
      dneg_w[a]   = (W+1)'(0) - (W+1)'(dir[a]);
      smag_next[a] = dir[a][W-1] ? dneg_w[a][W-1:0] : dir[a];
      side_next.sneg[a]  = dir[a][W-1];
      side_next.dzero[a] = (dir[a] == '0);
      side_next.zmiss[a] = (org[a] < box_lo[a]) || (org[a] > box_hi[a]);
    end
    for (int s = 0; s < NS; s++) begin
      side_next.dneg[s] = diff[s][W];
      dmag_next[s] = diff[s][W] ? W'((W+1)'(0) - diff[s]) : diff[s][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.valid <= 1'b0;
      for (int k = 0; k < W; k++) side_d[k].valid <= 1'b0;
    end else if (en) begin
      side_a.valid    <= side_next.valid;
      side_d[0].valid <= side_a.valid;
      for (int k = 1; k < W; k++) side_d[k].valid <= side_d[k-1].valid;
    end
    if (en) begin
      side_a.dzero <= side_next.dzero;
      side_a.zmiss <= side_next.zmiss;
      side_a.sneg  <= side_next.sneg;
      side_a.dneg  <= side_next.dneg;
      dmag <= dmag_next;
      smag <= smag_next;
      side_d[0].dzero <= side_a.dzero;
      side_d[0].zmiss <= side_a.zmiss;
      side_d[0].sneg  <= side_a.sneg;
      side_d[0].dneg  <= side_a.dneg;
      for (int k = 1; k < W; k++) begin
        side_d[k].dzero <= side_d[k-1].dzero;
        side_d[k].zmiss <= side_d[k-1].zmiss;
        side_d[k].sneg  <= side_d[k-1].sneg;
        side_d[k].dneg  <= side_d[k-1].dneg;
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    rbsi_div_pipe #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .dmag(dmag[s]),
      .smag(smag[s/2]),
      .quot(quot[s]),
      .sat (sat[s])
    );
  end

  rbsi_resolve #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_resolve (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .quot     (quot),
    .sat      (sat),
    .side     (side_d[W-1]),
    .out_valid(m_tvalid),
    .hit      (m_tuser[0]),
    .distance (distance)
  );

  assign m_tdata = OB'(distance);

endmodule

FILE: bench/tb_ray_box_slab_intersect_core.sv
// Self-checking bench for ray_box_slab_intersect_core: streams rays through the
// slab test under several box settings and compares every hit/distance result.
// Depends on rbsi_pkg and the core RTL.
module tb_ray_box_slab_intersect_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CW       = 32;
  localparam int          FB       = 16;
  localparam int          LATENCY  = CW + 3;
  localparam longint      MAX_POS  = 64'sd2147483647;
  localparam longint      MIN_NEG  = -64'sd2147483648;
  localparam logic [31:0] MISS_VAL = 32'hFFFF_0000;
  localparam logic [31:0] ONE      = 32'h0001_0000;
  localparam int          LIMIT    = 400000;

  typedef struct packed {
    logic [31:0] dz, dy, dx, oz, oy, ox;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] tdist;
  } hit_t;

  typedef struct packed {
    ray_t        ray;
    logic        typed;
    logic        hit;
    logic [31:0] tdist;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index = rbsi_pkg::REG_BOX_MIN_X;
  logic [31:0]  cfg_data = '0;

  longint box_lo[3];
  longint box_hi[3];
  hit_t   pending_hits[$];
  int     errors = 0;
  int     cycles = 0;
  int     stall = 0;
  bit     no_idle = 1'b0;

  // box all zero after reset
  row_t zero_box_rows[6] = '{
    '{ray: '{dz: 0, dy: 0, dx: 0, oz: 0, oy: 0, ox: 0}, typed: 1, hit: 1,
      tdist: 32'h8000_0000},
    '{ray: '{dz: 0, dy: 0, dx: 0, oz: 0, oy: 0, ox: ONE}, typed: 1, hit: 0, tdist: MISS_VAL},
    '{ray: '{dz: 0, dy: 0, dx: ONE, oz: 0, oy: 0, ox: 0}, typed: 1, hit: 1, tdist: 0},
    '{ray: '{dz: 0, dy: 0, dx: ONE, oz: 0, oy: 0, ox: -ONE}, typed: 1, hit: 1, tdist: ONE},
    '{ray: '{dz: 0, dy: 0, dx: ONE, oz: 0, oy: 0, ox: ONE}, typed: 1, hit: 0,
      tdist: MISS_VAL},
    '{ray: '{dz: 0, dy: 0, dx: -ONE, oz: 0, oy: 0, ox: -ONE}, typed: 1, hit: 0,
      tdist: MISS_VAL}
  };

  // box [-1,1] on every axis
  row_t unit_box_rows[12] = '{
    '{ray: '{dz: 0, dy: 0, dx: ONE, oz: 0, oy: 0, ox: -2*ONE}, typed: 1, hit: 1, tdist: ONE},
    '{ray: '{dz: 0, dy: 0, dx: 0, oz: 0, oy: 0, ox: 2*ONE}, typed: 1, hit: 0,
      tdist: MISS_VAL},
    '{ray: '{dz: ONE, dy: ONE, dx: ONE, oz: 0, oy: 0, ox: 0}, typed: 0, hit: 0, tdist: 0},
    '{ray: '{dz: 32'h8000_0000, dy: 32'h8000_0000, dx: 32'h8000_0000,
             oz: 32'h7FFF_FFFF, oy: 32'h7FFF_FFFF, ox: 32'h7FFF_FFFF},
      typed: 0, hit: 0, tdist: 0},
    '{ray: '{dz: 32'h7FFF_FFFF, dy: 32'h7FFF_FFFF, dx: 32'h7FFF_FFFF,
             oz: 32'h8000_0000, oy: 32'h8000_0000, ox: 32'h8000_0000},
      typed: 0, hit: 0, tdist: 0},
    '{ray: '{dz: 1, dy: 1, dx: 1, oz: -2*ONE, oy: -2*ONE, ox: -2*ONE}, typed: 0, hit: 0,
      tdist: 0},
    '{ray: '{dz: -1, dy: -1, dx: -1, oz: 2*ONE, oy: 2*ONE, ox: 2*ONE}, typed: 0, hit: 0,
      tdist: 0},
    '{ray: '{dz: 32'hFFFF_FFFF, dy: 0, dx: 1, oz: 0, oy: ONE, ox: -ONE}, typed: 0, hit: 0,
      tdist: 0},
    '{ray: '{dz: 32'h0000_8000, dy: 32'hFFFF_8000, dx: ONE, oz: -3*ONE, oy: 3*ONE, ox: -3*ONE},
      typed: 0, hit: 0, tdist: 0},
    '{ray: '{dz: 32'hFFFF_FFFF, dy: 32'hFFFF_FFFF, dx: 32'hFFFF_FFFF,
             oz: 32'hFFFF_FFFF, oy: 32'hFFFF_FFFF, ox: 32'hFFFF_FFFF},
      typed: 0, hit: 0, tdist: 0},
    '{ray: '{dz: 0, dy: 0, dx: 0, oz: -ONE, oy: ONE, ox: -ONE}, typed: 1, hit: 1,
      tdist: 32'h8000_0000},
    '{ray: '{dz: 0, dy: ONE, dx: 0, oz: 0, oy: -2*ONE, ox: 32'h0001_0001}, typed: 1, hit: 0,
      tdist: MISS_VAL}
  };

  ray_box_slab_intersect_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint plane_distance(longint plane, longint org, longint dir);
    bit                behind;
    bit                dir_neg;
    longint unsigned   dmag;
    longint unsigned   smag;
    longint unsigned   q;
    behind  = plane < org;
    dmag    = behind ? longint'(org - plane) : longint'(plane - org);
    dir_neg = dir < 0;
    smag    = dir_neg ? -dir : dir;
    q       = (dmag << FB) / smag;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    if (behind != dir_neg) return (q >= 64'h8000_0000) ? MIN_NEG : -longint'(q);
    return (q > MAX_POS) ? MAX_POS : longint'(q);
  endfunction

  function automatic hit_t intersect_ray(ray_t r);
    longint t_in;
    longint t_out;
    longint o;
    longint d;
    longint e;
    longint x;
    logic [31:0] org[3];
    logic [31:0] dir[3];
    bit     miss;
    hit_t   res;
    org  = '{r.ox, r.oy, r.oz};
    dir  = '{r.dx, r.dy, r.dz};
    t_in  = MIN_NEG;
    t_out = MAX_POS;
    miss  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      o = longint'(signed'(org[a]));
      d = longint'(signed'(dir[a]));
      if (d == 0) begin
        if (o < box_lo[a] || o > box_hi[a]) miss = 1'b1;
      end else begin
        e = plane_distance(d > 0 ? box_lo[a] : box_hi[a], o, d);
        x = plane_distance(d > 0 ? box_hi[a] : box_lo[a], o, d);
        if (e > t_in) t_in = e;
        if (x < t_out) t_out = x;
      end
    end
    if (t_out < 0 || t_in > t_out) miss = 1'b1;
    res.hit   = !miss;
    res.tdist = miss ? MISS_VAL : t_in[31:0];
    return res;
  endfunction

  function automatic ray_t random_ray();
    ray_t            r;
    logic [31:0]     org[3];
    logic [31:0]     dir[3];
    longint          center;
    longint unsigned span;
    int              k;
    k = $urandom_range(0, 7);
    for (int a = 0; a < 3; a++) begin
      if (k == 0) begin
        org[a] = $urandom;
        dir[a] = $urandom;
      end else begin
        center = (box_lo[a] + box_hi[a]) / 2;
        span   = ((box_hi[a] > box_lo[a]) ? box_hi[a] - box_lo[a] : box_lo[a] - box_hi[a]) / 2
                 + 4 * ONE;
        if (span > 64'h8000_0000) span = 64'h8000_0000;
        org[a] = 32'(center + longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span));
        dir[a] = $urandom_range(0, 1 << 19) - (1 << 18);
        if (k == 1 && $urandom_range(0, 1)) dir[a] = 0;
      end
    end
    r = '{dz: dir[2], dy: dir[1], dx: dir[0], oz: org[2], oy: org[1], ox: org[0]};
    return r;
  endfunction

  task automatic write_box(input logic [31:0] lo[3], input logic [31:0] hi[3]);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= rbsi_pkg::CFG_IDX_W'(i);
      cfg_data  <= (i < 3) ? lo[i] : hi[i - 3];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = longint'(signed'(lo[a]));
      box_hi[a] = longint'(signed'(hi[a]));
    end
  endtask

  task automatic send_ray(input ray_t r, input logic typed, input hit_t typed_res);
    int gap;
    hit_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    do @(posedge clk); while (!s_tready);
    predicted = intersect_ray(r);
    if (typed && predicted != typed_res)
      $display("table row disagrees with prediction: %h vs %h", typed_res, predicted);
    pending_hits.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall    <= 0;
    end else if (stall != 0) begin
      m_tready <= 1'b0;
      stall    <= stall - 1;
    end else if (m_tready && m_tvalid) begin
      int s;
      s = no_idle ? 0 : $urandom_range(0, 19);
      if (s > 0) begin
        m_tready <= 1'b0;
        stall    <= s - 1;
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      hit_t want;
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: hit=%b dist=%h", m_tuser, m_tdata);
      end else begin
        want = pending_hits.pop_front();
        if (m_tuser[0] !== want.hit || m_tdata !== want.tdist) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected hit=%b dist=%h, got hit=%b dist=%h",
                     want.hit, want.tdist, m_tuser[0], m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_ray_box_slab_intersect_core: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] lo[3];
    logic [31:0] hi[3];
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (zero_box_rows[i])
      send_ray(zero_box_rows[i].ray, zero_box_rows[i].typed,
               '{hit: zero_box_rows[i].hit, tdist: zero_box_rows[i].tdist});
    drain();

    lo = '{-ONE, -ONE, -ONE};
    hi = '{ONE, ONE, ONE};
    write_box(lo, hi);
    foreach (unit_box_rows[i])
      send_ray(unit_box_rows[i].ray, unit_box_rows[i].typed,
               '{hit: unit_box_rows[i].hit, tdist: unit_box_rows[i].tdist});
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
          hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        end
        1: begin
          lo = '{2*ONE, -ONE, 0};
          hi = '{-2*ONE, ONE, 3*ONE};
        end
        2: begin
          lo = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
          hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        end
        default: begin
          for (int a = 0; a < 3; a++) begin
            lo[a] = $urandom_range(0, 1 << 22) - (1 << 21);
            hi[a] = lo[a] + $urandom_range(0, 1 << 20);
          end
        end
      endcase
      write_box(lo, hi);
      no_idle = (p % 3 == 2);
      repeat (140) send_ray(random_ray(), 1'b0, '0);
      drain();
    end

    if (errors == 0 && pending_hits.size() == 0) begin
      $display("tb_ray_box_slab_intersect_core: done, clean");
    end else begin
      $display("tb_ray_box_slab_intersect_core: done, errors");
    end
    $finish;
  end

endmodule
